>>> rtl/core/slmc_pkg.sv
// Shared types and constants for the sorted line merge and compare block.
// Used by slmc_cfg, slmc_ctrl and the top module in rtl/core; depends on nothing.
package slmc_pkg;

    localparam int APB_AW = 4;
    localparam int APB_DW = 32;

    localparam logic [7:0] NL_BYTE = 8'd10;

    localparam logic [1:0] REG_HIDE_FIRST  = 2'd0;
    localparam logic [1:0] REG_HIDE_SECOND = 2'd1;
    localparam logic [1:0] REG_HIDE_THIRD  = 2'd2;

    localparam logic [1:0] COL_ONLY_A = 2'd1;
    localparam logic [1:0] COL_ONLY_B = 2'd2;
    localparam logic [1:0] COL_BOTH   = 2'd3;

    typedef enum logic [1:0] {
        ORD_EQUAL   = 2'd0,
        ORD_A_FIRST = 2'd1,
        ORD_B_FIRST = 2'd2
    } t_order;

    typedef struct packed {
        logic hide_first;
        logic hide_second;
        logic hide_third;
    } t_cfg;

    typedef struct packed {
        logic       finished;
        logic       want_b;
        logic       want_a;
        logic [7:0] line_length;
        logic [1:0] indent_tabs;
        logic       shown;
        logic [1:0] column;
    } t_result;

    typedef struct packed {
        logic held_a;
        logic held_b;
        logic ended_a;
        logic ended_b;
    } t_status;

endpackage

>>> rtl/core/slmc_line_ram.sv
// Synchronous line store: one write port and one registered read port.
// A read of the entry written in the same cycle returns the new byte.
module slmc_line_ram #(
    parameter int DEPTH = 256,
    parameter int AW    = 8
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [7:0]    i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [7:0]    o_rdata
);

    logic [7:0] r_mem [DEPTH];
    logic [7:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_we && (i_waddr == i_raddr)) begin
            r_rdata <= i_wdata;
        end else begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/core/slmc_cfg.sv
// APB register file holding the three column suppression flags.
// Depends on slmc_pkg for the register indexes and the t_cfg type.
module slmc_cfg (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_psel,
    input  logic                         i_penable,
    input  logic                         i_pwrite,
    input  logic [slmc_pkg::APB_AW-1:0]  i_paddr,
    input  logic [slmc_pkg::APB_DW-1:0]  i_pwdata,
    output logic [slmc_pkg::APB_DW-1:0]  o_prdata,
    output slmc_pkg::t_cfg               o_cfg
);

    slmc_pkg::t_cfg r_cfg;
    slmc_pkg::t_cfg n_cfg;
    logic           wr_en;
    logic [1:0]     reg_idx;

    assign wr_en   = i_psel && i_penable && i_pwrite;
    assign reg_idx = i_paddr[3:2];

    always_comb begin
        n_cfg = r_cfg;
        if (wr_en) begin
            case (reg_idx)
                slmc_pkg::REG_HIDE_FIRST:  n_cfg.hide_first  = i_pwdata[0];
                slmc_pkg::REG_HIDE_SECOND: n_cfg.hide_second = i_pwdata[0];
                slmc_pkg::REG_HIDE_THIRD:  n_cfg.hide_third  = i_pwdata[0];
                default:                   n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    always_comb begin
        case (reg_idx)
            slmc_pkg::REG_HIDE_FIRST:  o_prdata = {31'd0, r_cfg.hide_first};
            slmc_pkg::REG_HIDE_SECOND: o_prdata = {31'd0, r_cfg.hide_second};
            slmc_pkg::REG_HIDE_THIRD:  o_prdata = {31'd0, r_cfg.hide_third};
            default:                   o_prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

>>> rtl/core/slmc_ctrl.sv
// Line fill, byte compare and verdict logic around the two line stores.
// Depends on slmc_pkg and slmc_line_ram; both stores are read at the next fill position.
module slmc_ctrl #(
    parameter int LINE_BYTES = 256
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic              i_stream,
    input  logic [7:0]        i_data,
    input  logic              i_eof,
    input  slmc_pkg::t_cfg    i_cfg,
    output logic              o_res_valid,
    output slmc_pkg::t_result o_res,
    output slmc_pkg::t_status o_status
);

    localparam int AW = $clog2(LINE_BYTES);
    localparam logic [AW-1:0] LAST_POS = AW'(LINE_BYTES - 1);

    logic [AW-1:0]    r_fill, n_fill;
    logic [AW-1:0]    r_len_a, n_len_a;
    logic [AW-1:0]    r_len_b, n_len_b;
    slmc_pkg::t_order r_order, n_order;
    slmc_pkg::t_order cmp_order;
    logic             r_zero, n_zero;
    slmc_pkg::t_status r_st, n_st;

    logic             want_a, want_b, want;
    logic             we_a, we_b;
    logic [7:0]       rd_a, rd_b;
    logic             line_end;
    logic [7:0]       cmp_byte, other_byte, o_byte;
    logic [AW-1:0]    other_len;
    logic             other_held;
    logic             emit, emit_fin;
    logic [1:0]       emit_col;
    logic [AW-1:0]    emit_len;
    logic [AW+7:0]    len_wide;
    logic             hidden;
    logic [1:0]       tabs;

    slmc_line_ram #(.DEPTH(LINE_BYTES), .AW(AW)) u_store_a (
        .i_clk   (i_clk),
        .i_we    (we_a),
        .i_waddr (r_fill),
        .i_wdata (i_data),
        .i_raddr (n_fill),
        .o_rdata (rd_a)
    );

    slmc_line_ram #(.DEPTH(LINE_BYTES), .AW(AW)) u_store_b (
        .i_clk   (i_clk),
        .i_we    (we_b),
        .i_waddr (r_fill),
        .i_wdata (i_data),
        .i_raddr (n_fill),
        .o_rdata (rd_b)
    );

    assign want_a = !(r_st.held_a || r_st.ended_a);
    assign want_b = !want_a && !(r_st.held_b || r_st.ended_b);
    assign want   = i_stream ? want_b : want_a;

    assign line_end   = (i_data == slmc_pkg::NL_BYTE) || (r_fill == LAST_POS);
    assign cmp_byte   = line_end ? 8'd0 : i_data;
    assign other_len  = i_stream ? r_len_a : r_len_b;
    assign other_held = i_stream ? r_st.held_a : r_st.held_b;
    assign other_byte = i_stream ? rd_a : rd_b;
    assign o_byte     = (r_fill < other_len) ? other_byte : 8'd0;

    always_comb begin
        cmp_order = r_order;
        if (other_held && (r_order == slmc_pkg::ORD_EQUAL)) begin
            if (cmp_byte < o_byte) begin
                cmp_order = i_stream ? slmc_pkg::ORD_B_FIRST : slmc_pkg::ORD_A_FIRST;
            end else if (cmp_byte > o_byte) begin
                cmp_order = i_stream ? slmc_pkg::ORD_A_FIRST : slmc_pkg::ORD_B_FIRST;
            end
        end
    end

    always_comb begin
        n_fill   = r_fill;
        n_len_a  = r_len_a;
        n_len_b  = r_len_b;
        n_order  = r_order;
        n_zero   = r_zero;
        n_st     = r_st;
        we_a     = 1'b0;
        we_b     = 1'b0;
        emit     = 1'b0;
        emit_fin = 1'b0;
        emit_col = slmc_pkg::COL_BOTH;
        emit_len = '0;
        if (i_valid && want) begin
            if (i_eof) begin
                n_fill  = '0;
                n_zero  = 1'b0;
                n_order = slmc_pkg::ORD_EQUAL;
                if (i_stream) begin
                    n_st.ended_b = 1'b1;
                end else begin
                    n_st.ended_a = 1'b1;
                end
                if (other_held) begin
                    emit     = 1'b1;
                    emit_col = i_stream ? slmc_pkg::COL_ONLY_A : slmc_pkg::COL_ONLY_B;
                    emit_len = other_len;
                    if (i_stream) begin
                        n_st.held_a = 1'b0;
                    end else begin
                        n_st.held_b = 1'b0;
                    end
                end else if (i_stream ? r_st.ended_a : r_st.ended_b) begin
                    emit     = 1'b1;
                    emit_fin = 1'b1;
                end
            end else begin
                if (r_fill == '0) begin
                    if (i_stream) begin
                        n_len_b = '0;
                    end else begin
                        n_len_a = '0;
                    end
                end
                if (!line_end) begin
                    if (!r_zero) begin
                        if (i_data == 8'd0) begin
                            n_zero = 1'b1;
                        end else if (i_stream) begin
                            we_b    = 1'b1;
                            n_len_b = r_fill + AW'(1);
                        end else begin
                            we_a    = 1'b1;
                            n_len_a = r_fill + AW'(1);
                        end
                        n_order = cmp_order;
                    end
                    n_fill = r_fill + AW'(1);
                end else begin
                    if (!r_zero) begin
                        n_order = cmp_order;
                    end
                    n_fill = '0;
                    n_zero = 1'b0;
                    if (i_stream) begin
                        n_st.held_b = 1'b1;
                    end else begin
                        n_st.held_a = 1'b1;
                    end
                    if (other_held) begin
                        emit = 1'b1;
                        case (n_order)
                            slmc_pkg::ORD_A_FIRST: begin
                                emit_col    = slmc_pkg::COL_ONLY_A;
                                n_st.held_a = 1'b0;
                            end
                            slmc_pkg::ORD_B_FIRST: begin
                                emit_col    = slmc_pkg::COL_ONLY_B;
                                n_st.held_b = 1'b0;
                            end
                            default: begin
                                emit_col    = slmc_pkg::COL_BOTH;
                                n_st.held_a = 1'b0;
                                n_st.held_b = 1'b0;
                            end
                        endcase
                        emit_len = (emit_col == slmc_pkg::COL_ONLY_B) ? n_len_b : n_len_a;
                        n_order  = slmc_pkg::ORD_EQUAL;
                    end else if (i_stream ? r_st.ended_a : r_st.ended_b) begin
                        emit     = 1'b1;
                        emit_col = i_stream ? slmc_pkg::COL_ONLY_B : slmc_pkg::COL_ONLY_A;
                        emit_len = i_stream ? n_len_b : n_len_a;
                        n_order  = slmc_pkg::ORD_EQUAL;
                        if (i_stream) begin
                            n_st.held_b = 1'b0;
                        end else begin
                            n_st.held_a = 1'b0;
                        end
                    end
                end
            end
        end
    end

    always_comb begin
        case (emit_col)
            slmc_pkg::COL_ONLY_A: begin
                hidden = i_cfg.hide_first;
                tabs   = 2'd0;
            end
            slmc_pkg::COL_ONLY_B: begin
                hidden = i_cfg.hide_second;
                tabs   = 2'd1 - {1'b0, i_cfg.hide_first};
            end
            default: begin
                hidden = i_cfg.hide_third;
                tabs   = 2'd2 - {1'b0, i_cfg.hide_first} - {1'b0, i_cfg.hide_second};
            end
        endcase
    end

    assign len_wide = {8'd0, emit_len};

    always_comb begin
        o_res.column      = emit_col;
        o_res.shown       = !(hidden || emit_fin);
        o_res.indent_tabs = (hidden || emit_fin) ? 2'd0 : tabs;
        o_res.line_length = emit_fin ? 8'd0 : len_wide[7:0];
        o_res.want_a      = !(n_st.held_a || n_st.ended_a);
        o_res.want_b      = (n_st.held_a || n_st.ended_a) && !(n_st.held_b || n_st.ended_b);
        o_res.finished    = n_st.ended_a && n_st.ended_b;
    end

    assign o_res_valid = emit;
    assign o_status    = r_st;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill  <= '0;
            r_len_a <= '0;
            r_len_b <= '0;
            r_order <= slmc_pkg::ORD_EQUAL;
            r_zero  <= 1'b0;
            r_st    <= '0;
        end else begin
            r_fill  <= n_fill;
            r_len_a <= n_len_a;
            r_len_b <= n_len_b;
            r_order <= n_order;
            r_zero  <= n_zero;
            r_st    <= n_st;
        end
    end

endmodule

>>> rtl/core/sorted_line_merge_compare_top.sv
// Sorted line merge and compare: one byte item per cycle, back to back, while the output
// register is empty or being taken. Each accepted byte compares against the other line's
// byte from a registered read at the next fill position, so a verdict is held in the
// output register from the cycle after the newline or end item that causes it. Each line
// store has a single read port. Synchronous active-low reset clears all control state;
// the line stores are not cleared and no clearing pass runs.
module sorted_line_merge_compare_top #(
    parameter int LINE_BYTES = 256
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [slmc_pkg::APB_AW-1:0] paddr,
    input  logic [slmc_pkg::APB_DW-1:0] pwdata,
    output logic [slmc_pkg::APB_DW-1:0] prdata,
    output logic                        pready,
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    input  logic [7:0]                  s_axis_tdata,  // data
    input  logic [0:0]                  s_axis_tuser,  // stream
    input  logic                        s_axis_tlast,  // end_of_file
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    // column[1:0], shown[2], indent_tabs[4:3], line_length[12:5], want_a[13], want_b[14]
    output logic [15:0]                 m_axis_tdata,
    output logic                        m_axis_tlast   // finished
);

    slmc_pkg::t_cfg    cfg;
    slmc_pkg::t_result res;
    slmc_pkg::t_status status;
    logic              res_valid;
    logic              in_acc;
    logic              r_out_valid;
    slmc_pkg::t_result r_out;

    assign pready = 1'b1;

    slmc_cfg u_cfg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_psel    (psel),
        .i_penable (penable),
        .i_pwrite  (pwrite),
        .i_paddr   (paddr),
        .i_pwdata  (pwdata),
        .o_prdata  (prdata),
        .o_cfg     (cfg)
    );

    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign in_acc        = s_axis_tvalid && s_axis_tready;

    slmc_ctrl #(.LINE_BYTES(LINE_BYTES)) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (in_acc),
        .i_stream    (s_axis_tuser[0]),
        .i_data      (s_axis_tdata),
        .i_eof       (s_axis_tlast),
        .i_cfg       (cfg),
        .o_res_valid (res_valid),
        .o_res       (res),
        .o_status    (status)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_valid) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_valid) begin
            r_out <= res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {1'b0, r_out.want_b, r_out.want_a, r_out.line_length,
                            r_out.indent_tabs, r_out.shown, r_out.column};
    assign m_axis_tlast  = r_out.finished;

    a_held_a_not_ended: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(status.held_a && status.ended_a))
        else $error("stream A holds a line after it ended");

    a_held_b_not_ended: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(status.held_b && status.ended_b))
        else $error("stream B holds a line after it ended");

    a_result_from_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> $past(in_acc))
        else $error("result appeared without an accepted item");

    a_finished_wants_none: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tlast) |-> (!m_axis_tdata[13] && !m_axis_tdata[14]
            && !m_axis_tdata[2]))
        else $error("finished verdict still wants a stream or is shown");

endmodule
